FILE: src/wrss_pkg.sv
package wrss_pkg;

	localparam int DEF_STATE_COUNT = 6;
	localparam int ROW_COUNT       = 6;
	localparam int WEIGHT_W        = 7;
	localparam int ROW_W           = ROW_COUNT * WEIGHT_W;
	localparam int SLOT_W          = 17;
	localparam int TIMING_W        = 3 * SLOT_W;
	localparam int CFG_IDX_W       = 4;
	localparam int CFG_DATA_W      = TIMING_W;
	localparam int UNIT_W          = 10;
	localparam int SPREAD_W        = 16;
	localparam int MS_PER_SEC      = 1000;

	localparam logic [CFG_IDX_W-1:0] REG_TIMING_LOW  = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_TIMING_HIGH = CFG_IDX_W'(7);

	localparam logic [1:0] CMD_TICK    = 2'd0;
	localparam logic [1:0] CMD_ENABLE  = 2'd1;
	localparam logic [1:0] CMD_DISABLE = 2'd2;

	typedef struct packed {
		logic [2:0] animation;
		logic [3:0] speed;
		logic [4:0] variance;
		logic [4:0] median;
	} slot_t;

	typedef struct packed {
		logic [2:0] row_sel;
		logic [2:0] weight_sel;
		logic [2:0] slot_sel;
	} cfg_rd_t;

	typedef struct packed {
		logic [7:0] restore_speed;
		logic       restore_valid;
		logic [3:0] speed;
		logic [2:0] animation;
		logic [2:0] state_idx;
		logic       transitioned;
	} result_t;

endpackage

FILE: src/wrss_sub.sv
module wrss_sub (
	input  logic [wrss_pkg::UNIT_W-1:0] a,
	input  logic [wrss_pkg::UNIT_W-1:0] b,
	output logic [wrss_pkg::UNIT_W-1:0] diff,
	output logic                        borrow
);
	import wrss_pkg::*;

	assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

FILE: src/wrss_cfg.sv
module wrss_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [wrss_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [wrss_pkg::CFG_DATA_W-1:0]   wr_data,
	input  wrss_pkg::cfg_rd_t                 rd,
	output logic [wrss_pkg::WEIGHT_W-1:0]     weight,
	output wrss_pkg::slot_t                   slot
);
	import wrss_pkg::*;

	logic [ROW_W-1:0]    row_q [ROW_COUNT];
	logic [TIMING_W-1:0] timing_low_q;
	logic [TIMING_W-1:0] timing_high_q;
	logic [ROW_W-1:0]    row_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROW_COUNT; i++) begin
				row_q[i] <= '0;
			end
			timing_low_q  <= '0;
			timing_high_q <= '0;
		end else if (wr_en) begin
			for (int i = 0; i < ROW_COUNT; i++) begin
				if (wr_index == CFG_IDX_W'(i)) begin
					row_q[i] <= wr_data[ROW_W-1:0];
				end
			end
			if (wr_index == REG_TIMING_LOW) begin
				timing_low_q <= wr_data;
			end
			if (wr_index == REG_TIMING_HIGH) begin
				timing_high_q <= wr_data;
			end
		end
	end

	always_comb begin
		row_sel = '0;
		for (int i = 0; i < ROW_COUNT; i++) begin
			if (rd.row_sel == 3'(i)) begin
				row_sel = row_q[i];
			end
		end
		weight = '0;
		for (int j = 0; j < ROW_COUNT; j++) begin
			if (rd.weight_sel == 3'(j)) begin
				weight = row_sel[WEIGHT_W*j +: WEIGHT_W];
			end
		end
	end

	always_comb begin
		unique case (rd.slot_sel)
			3'd0:    slot = slot_t'(timing_low_q[0 +: SLOT_W]);
			3'd1:    slot = slot_t'(timing_low_q[SLOT_W +: SLOT_W]);
			3'd2:    slot = slot_t'(timing_low_q[2*SLOT_W +: SLOT_W]);
			3'd3:    slot = slot_t'(timing_high_q[0 +: SLOT_W]);
			3'd4:    slot = slot_t'(timing_high_q[SLOT_W +: SLOT_W]);
			3'd5:    slot = slot_t'(timing_high_q[2*SLOT_W +: SLOT_W]);
			default: slot = '0;
		endcase
	end

endmodule

FILE: src/wrss_core.sv
module wrss_core #(
	parameter int STATE_COUNT = wrss_pkg::DEF_STATE_COUNT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      in_command,
	input  logic [31:0]                     in_now_ms,
	input  logic [6:0]                      in_pick_roll,
	input  logic [wrss_pkg::SPREAD_W-1:0]   in_spread_roll,
	input  logic [7:0]                      in_current_speed,
	output wrss_pkg::cfg_rd_t               cfg_rd,
	input  logic [wrss_pkg::WEIGHT_W-1:0]   cfg_weight,
	input  wrss_pkg::slot_t                 cfg_slot,
	output logic                            out_valid,
	input  logic                            out_ready,
	output wrss_pkg::result_t               out_result
);
	import wrss_pkg::*;

	localparam int J_W = $clog2(STATE_COUNT);
	localparam int BIT_W = $clog2(SPREAD_W);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CHECK = 4'd1;
	localparam logic [3:0] ST_PICK  = 4'd2;
	localparam logic [3:0] ST_SLOT  = 4'd3;
	localparam logic [3:0] ST_DIV   = 4'd4;
	localparam logic [3:0] ST_DELAY = 4'd5;
	localparam logic [3:0] ST_MUL   = 4'd6;
	localparam logic [3:0] ST_ADD   = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;

	logic [3:0]          st_q;
	logic [1:0]          cmd_q;
	logic [31:0]         now_q;
	logic [6:0]          roll_q;
	logic [SPREAD_W-1:0] spread_q;
	logic [7:0]          cur_speed_q;

	logic [2:0]          cur_state_q;
	logic [31:0]         deadline_q;
	logic                enabled_q;
	logic [7:0]          saved_speed_q;

	logic [J_W-1:0]      j_q;
	logic [UNIT_W-1:0]   accum_q;
	logic [J_W-1:0]      chosen_q;
	logic [BIT_W-1:0]    bit_q;
	logic [5:0]          rem_q;
	logic [6:0]          delay_q;
	logic [16:0]         prod_q;
	slot_t               slot_q;
	result_t             res_q;
	result_t             out_q;
	logic                out_valid_q;

	logic [UNIT_W-1:0]   unit_a;
	logic [UNIT_W-1:0]   unit_b;
	logic [UNIT_W-1:0]   unit_diff;
	logic                unit_borrow;
	logic [6:0]          rem_shift;
	logic                due;
	logic                restore_now;

	wrss_sub u_sub (
		.a      (unit_a),
		.b      (unit_b),
		.diff   (unit_diff),
		.borrow (unit_borrow)
	);

	assign rem_shift = {rem_q, spread_q[bit_q]};
	assign due = (deadline_q == '0) || (now_q >= deadline_q);
	assign restore_now = (cmd_q == CMD_DISABLE) && enabled_q;

	assign cfg_rd.row_sel    = cur_state_q;
	assign cfg_rd.weight_sel = 3'(j_q);
	assign cfg_rd.slot_sel   = 3'(chosen_q);

	always_comb begin
		unique case (st_q)
			ST_PICK: begin
				unit_a = UNIT_W'(roll_q);
				unit_b = accum_q;
			end
			ST_DIV: begin
				unit_a = UNIT_W'(rem_shift);
				unit_b = UNIT_W'({slot_q.variance, 1'b0});
			end
			ST_DELAY: begin
				unit_a = UNIT_W'(slot_q.median) + UNIT_W'(rem_q);
				unit_b = UNIT_W'(slot_q.variance);
			end
			default: begin
				unit_a = '0;
				unit_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q       <= in_command;
			now_q       <= in_now_ms;
			roll_q      <= in_pick_roll;
			spread_q    <= in_spread_roll;
			cur_speed_q <= in_current_speed;
		end
		unique case (st_q)
			ST_CHECK: begin
				j_q      <= '0;
				accum_q  <= '0;
				chosen_q <= '0;
				res_q    <= result_t'{
					restore_speed: restore_now ? saved_speed_q : 8'd0,
					restore_valid: restore_now,
					speed:         4'd0,
					animation:     3'd0,
					state_idx:     cur_state_q,
					transitioned:  1'b0
				};
			end
			ST_PICK: begin
				if (!unit_borrow && cfg_weight != '0) begin
					chosen_q <= j_q;
				end
				accum_q <= accum_q + UNIT_W'(cfg_weight);
				j_q     <= j_q + 1'b1;
			end
			ST_SLOT: begin
				slot_q <= cfg_slot;
				rem_q  <= '0;
				bit_q  <= BIT_W'(SPREAD_W - 1);
			end
			ST_DIV: begin
				rem_q <= unit_borrow ? rem_shift[5:0] : unit_diff[5:0];
				bit_q <= bit_q - 1'b1;
			end
			ST_DELAY: begin
				delay_q <= unit_borrow ? '0 : unit_diff[6:0];
			end
			ST_MUL: begin
				prod_q <= 17'(delay_q) * 17'(MS_PER_SEC);
			end
			ST_ADD: begin
				res_q <= result_t'{
					restore_speed: 8'd0,
					restore_valid: 1'b0,
					speed:         slot_q.speed,
					animation:     slot_q.animation,
					state_idx:     3'(chosen_q),
					transitioned:  1'b1
				};
			end
			default: begin
			end
		endcase
		if (st_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_IDLE;
			cur_state_q   <= '0;
			deadline_q    <= '0;
			enabled_q     <= 1'b0;
			saved_speed_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						st_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					st_q <= ST_DONE;
					priority if (cmd_q == CMD_TICK) begin
						if (enabled_q && due) begin
							st_q <= ST_PICK;
						end
					end else if (cmd_q == CMD_ENABLE) begin
						if (!enabled_q) begin
							deadline_q    <= '0;
							saved_speed_q <= cur_speed_q;
							enabled_q     <= 1'b1;
						end
					end else if (cmd_q == CMD_DISABLE) begin
						if (enabled_q) begin
							deadline_q <= '0;
							enabled_q  <= 1'b0;
						end
					end else begin
					end
				end
				ST_PICK: begin
					if (j_q == J_W'(STATE_COUNT - 1)) begin
						st_q <= ST_SLOT;
					end
				end
				ST_SLOT: begin
					st_q <= (cfg_slot.variance == '0) ? ST_DELAY : ST_DIV;
				end
				ST_DIV: begin
					if (bit_q == '0) begin
						st_q <= ST_DELAY;
					end
				end
				ST_DELAY: begin
					st_q <= ST_MUL;
				end
				ST_MUL: begin
					st_q <= ST_ADD;
				end
				ST_ADD: begin
					cur_state_q <= 3'(chosen_q);
					deadline_q  <= now_q + 32'(prod_q);
					st_q        <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						st_q        <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready   = (st_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign out_result = out_q;

endmodule

FILE: src/weighted_random_state_sequencer_unit.sv
// Six-state Markov sequencer with random dwell time.
// Input stream (s_axis): one transfer per command. tuser holds the command
// (tick, enable, disable); tdata holds now_ms, pick_roll, spread_roll and
// current_speed. Every accepted command produces exactly one result transfer.
// Output stream (m_axis): tuser flags a state change and a speed restore;
// tdata holds the new state, its animation and speed, and the restore speed.
// Config channel (cfg_*): always ready; index 0..5 loads a transition row,
// 6 and 7 load the timing words. Write only while no command is in flight.
// Enable, disable and ticks that do not transition pass from CHECK to DONE.
// A tick that transitions walks the row one weight per cycle, then, with a
// nonzero variance, runs a restoring modulo on the shared subtractor, then
// forms the delay from median, remainder and variance, then does a multiply
// and an add. One command is worked at a time; the next can be accepted as
// soon as a result is placed in the output register.
// Reset clears the tables, state 0, deadline 0 and disabled.
// A stalled result sits in the output register; the next command is still
// accepted and worked, and its result waits until that register frees.
module weighted_random_state_sequencer_unit #(
	parameter int STATE_COUNT = wrss_pkg::DEF_STATE_COUNT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// now_ms[31:0], pick_roll[38:32], spread_roll[54:39], current_speed[62:55]
	input  logic [63:0]                        s_axis_tdata,
	// command[1:0]
	input  logic [1:0]                         s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// state_idx[2:0], animation[5:3], speed[9:6], restore_speed[17:10]
	output logic [23:0]                        m_axis_tdata,
	// transitioned[0], restore_valid[1]
	output logic [1:0]                         m_axis_tuser,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [wrss_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wrss_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import wrss_pkg::*;

	cfg_rd_t               cfg_rd;
	logic [WEIGHT_W-1:0]   cfg_weight;
	slot_t                 cfg_slot;
	result_t               result;

	assign cfg_ready = 1'b1;

	wrss_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.rd       (cfg_rd),
		.weight   (cfg_weight),
		.slot     (cfg_slot)
	);

	wrss_core #(
		.STATE_COUNT (STATE_COUNT)
	) u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (s_axis_tvalid),
		.in_ready         (s_axis_tready),
		.in_command       (s_axis_tuser),
		.in_now_ms        (s_axis_tdata[31:0]),
		.in_pick_roll     (s_axis_tdata[38:32]),
		.in_spread_roll   (s_axis_tdata[54:39]),
		.in_current_speed (s_axis_tdata[62:55]),
		.cfg_rd           (cfg_rd),
		.cfg_weight       (cfg_weight),
		.cfg_slot         (cfg_slot),
		.out_valid        (m_axis_tvalid),
		.out_ready        (m_axis_tready),
		.out_result       (result)
	);

	assign m_axis_tdata = {6'd0, result.restore_speed, result.speed,
		result.animation, result.state_idx};
	assign m_axis_tuser = {result.restore_valid, result.transitioned};

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while a command is in flight");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("transition and restore in one result");

	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (32'(m_axis_tdata[2:0]) < STATE_COUNT))
		else $error("state index out of range");

	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata[9:3] == '0))
		else $error("animation or speed set without a transition");

endmodule

FILE: verif/weighted_random_state_sequencer_unit_test.sv
module weighted_random_state_sequencer_unit_test;
	import wrss_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 155;

	localparam logic [1:0] CMD_RESERVED = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_ROW0 = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ROW1 = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_ROW2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_ROW3 = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_ROW4 = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_ROW5 = CFG_IDX_W'(5);

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_ALTERNATE} rx_mode_t;

	typedef struct packed {
		logic                  is_write;
		logic [CFG_IDX_W-1:0]  reg_index;
		logic [CFG_DATA_W-1:0] reg_value;
		logic [1:0]            cmd;
		logic [31:0]           now_ms;
		logic [6:0]            pick_roll;
		logic [15:0]           spread_roll;
		logic [7:0]            cur_speed;
		logic                  typed;
		result_t               want;
	} directed_row_t;

	localparam result_t NOTHING = '0;
	localparam logic [ROW_W-1:0] PCT_ROW = {7'd20, 7'd20, 7'd20, 7'd20, 7'd10, 7'd10};
	localparam logic [ROW_W-1:0] SPLIT_ROW = {7'd50, 7'd0, 7'd0, 7'd50, 7'd0, 7'd0};
	localparam logic [TIMING_W-1:0] HIGH_TIMING =
		{3'd7, 4'd15, 5'd31, 5'd0, 3'd0, 4'd0, 5'd0, 5'd0, 3'd5, 4'd9, 5'd0, 5'd2};

	localparam int DIRECTED_ROWS = 31;
	localparam directed_row_t DIRECTED[DIRECTED_ROWS] = '{
		'{1'b0, REG_ROW0, '0, CMD_TICK, 32'd0, 7'd0, 16'd0, 8'd0, 1'b1, NOTHING},
		'{1'b0, REG_ROW0, '0, CMD_DISABLE, 32'd5, 7'd3, 16'd7, 8'd9, 1'b1, NOTHING},
		'{1'b0, REG_ROW0, '0, CMD_RESERVED, 32'd0, 7'd0, 16'd0, 8'd0, 1'b1, NOTHING},
		'{1'b0, REG_ROW0, '0, CMD_ENABLE, 32'd0, 7'd0, 16'd0, 8'hFF, 1'b1, NOTHING},
		'{1'b0, REG_ROW0, '0, CMD_ENABLE, 32'd0, 7'd0, 16'd0, 8'h00, 1'b1, NOTHING},
		'{1'b0, REG_ROW0, '0, CMD_TICK, 32'hFFFF_FFFF, 7'd127, 16'hFFFF, 8'd0, 1'b1,
			result_t'{8'd0, 1'b0, 4'd0, 3'd0, 3'd0, 1'b1}},
		'{1'b0, REG_ROW0, '0, CMD_TICK, 32'd0, 7'd0, 16'd0, 8'd0, 1'b1, NOTHING},
		'{1'b0, REG_ROW0, '0, CMD_DISABLE, 32'd0, 7'd0, 16'd0, 8'd0, 1'b1,
			result_t'{8'hFF, 1'b1, 4'd0, 3'd0, 3'd0, 1'b0}},
		'{1'b1, REG_ROW0, '1, CMD_TICK, '0, '0, '0, '0, 1'b0, NOTHING},
		'{1'b1, REG_ROW1, CFG_DATA_W'(SPLIT_ROW), CMD_TICK, '0, '0, '0, '0, 1'b0, NOTHING},
		'{1'b1, REG_ROW2, '0, CMD_TICK, '0, '0, '0, '0, 1'b0, NOTHING},
		'{1'b1, REG_ROW3, CFG_DATA_W'(PCT_ROW), CMD_TICK, '0, '0, '0, '0, 1'b0, NOTHING},
		'{1'b1, REG_ROW4, CFG_DATA_W'(PCT_ROW), CMD_TICK, '0, '0, '0, '0, 1'b0, NOTHING},
		'{1'b1, REG_ROW5, CFG_DATA_W'(PCT_ROW), CMD_TICK, '0, '0, '0, '0, 1'b0, NOTHING},
		'{1'b1, REG_TIMING_LOW, '1, CMD_TICK, '0, '0, '0, '0, 1'b0, NOTHING},
		'{1'b1, REG_TIMING_HIGH, HIGH_TIMING, CMD_TICK, '0, '0, '0, '0, 1'b0, NOTHING},
		'{1'b0, REG_ROW0, '0, CMD_ENABLE, 32'd0, 7'd0, 16'd0, 8'h5A, 1'b0, NOTHING},
		'{1'b0, REG_ROW0, '0, CMD_TICK, 32'd1000, 7'd127, 16'd0, 8'd0, 1'b1,
			result_t'{8'd0, 1'b0, 4'd15, 3'd7, 3'd1, 1'b1}},
		'{1'b0, REG_ROW0, '0, CMD_TICK, 32'd1000, 7'd0, 16'hFFFF, 8'd0, 1'b1,
			result_t'{8'd0, 1'b0, 4'd15, 3'd7, 3'd2, 1'b1}},
		'{1'b0, REG_ROW0, '0, CMD_TICK, 32'd1999, 7'd0, 16'd0, 8'd0, 1'b1,
			result_t'{8'd0, 1'b0, 4'd0, 3'd0, 3'd2, 1'b0}},
		'{1'b0, REG_ROW0, '0, CMD_TICK, 32'd2000, 7'd99, 16'd61, 8'd0, 1'b1,
			result_t'{8'd0, 1'b0, 4'd15, 3'd7, 3'd0, 1'b1}},
		'{1'b0, REG_ROW0, '0, CMD_TICK, 32'd62999, 7'd127, 16'd0, 8'd0, 1'b1, NOTHING},
		'{1'b0, REG_ROW0, '0, CMD_TICK, 32'd63000, 7'd127, 16'd0, 8'd0, 1'b1,
			result_t'{8'd0, 1'b0, 4'd15, 3'd7, 3'd1, 1'b1}},
		'{1'b0, REG_ROW0, '0, CMD_TICK, 32'd63000, 7'd100, 16'd0, 8'd0, 1'b1,
			result_t'{8'd0, 1'b0, 4'd15, 3'd7, 3'd5, 1'b1}},
		'{1'b0, REG_ROW0, '0, CMD_TICK, 32'd63000, 7'd0, 16'd4, 8'd0, 1'b0, NOTHING},
		'{1'b0, REG_ROW0, '0, CMD_TICK, 32'hFFFF_FC18, 7'd55, 16'h8000, 8'd0, 1'b0, NOTHING},
		'{1'b0, REG_ROW0, '0, CMD_TICK, 32'hFFFF_FC19, 7'd0, 16'h1234, 8'd0, 1'b0, NOTHING},
		'{1'b0, REG_ROW0, '0, CMD_RESERVED, 32'd0, 7'd0, 16'd0, 8'd0, 1'b0, NOTHING},
		'{1'b0, REG_ROW0, '0, CMD_DISABLE, 32'd0, 7'd0, 16'd0, 8'd0, 1'b1,
			result_t'{8'h5A, 1'b1, 4'd0, 3'd0, 3'd0, 1'b0}},
		'{1'b0, REG_ROW0, '0, CMD_DISABLE, 32'd0, 7'd0, 16'd0, 8'd0, 1'b1, NOTHING},
		'{1'b0, REG_ROW0, '0, CMD_TICK, 32'hFFFF_FFFF, 7'd0, 16'd0, 8'd0, 1'b1, NOTHING}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [63:0]           s_axis_tdata = '0;
	logic [1:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [23:0]           m_axis_tdata;
	logic [1:0]            m_axis_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic [ROW_W-1:0]    seq_rows [ROW_COUNT];
	logic [TIMING_W-1:0] seq_timing [2];
	logic [2:0]          seq_state;
	logic [31:0]         seq_deadline;
	logic                seq_enabled;
	logic [7:0]          seq_saved_speed;

	result_t     pending_outcomes [$];
	int          mismatches = 0;
	int          idle_cycles = 0;
	int          burst_left = 0;
	logic [31:0] wall_ms = '0;
	rx_mode_t    rx_mode = RX_OPEN;
	int          rx_run = 0;

	weighted_random_state_sequencer_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic result_t step_sequencer(logic [1:0] cmd, logic [31:0] now,
		logic [6:0] roll, logic [15:0] spread, logic [7:0] cur);
		result_t     outcome;
		int unsigned accum;
		logic [2:0]  next_state;
		logic [6:0]  weight;
		slot_t       dwell;
		int          delay_s;
		outcome = '0;
		case (cmd)
			CMD_TICK: begin
				if (seq_enabled && !(seq_deadline != 0 && now < seq_deadline)) begin
					accum = 0;
					next_state = '0;
					for (int j = 0; j < DEF_STATE_COUNT; j++) begin
						weight = seq_rows[seq_state][WEIGHT_W*j +: WEIGHT_W];
						if (accum <= roll && weight != 0)
							next_state = 3'(j);
						accum += weight;
					end
					dwell = seq_timing[next_state / 3][SLOT_W*(next_state % 3) +: SLOT_W];
					delay_s = int'(dwell.median);
					if (dwell.variance != 0)
						delay_s += int'(32'(spread) % (2 * 32'(dwell.variance)))
							- int'(dwell.variance);
					if (delay_s < 0)
						delay_s = 0;
					seq_state = next_state;
					seq_deadline = now + 32'(delay_s * MS_PER_SEC);
					outcome.transitioned = 1'b1;
					outcome.speed = dwell.speed;
					outcome.animation = dwell.animation;
				end
			end
			CMD_ENABLE: begin
				if (!seq_enabled) begin
					seq_deadline = '0;
					seq_saved_speed = cur;
					seq_enabled = 1'b1;
				end
			end
			CMD_DISABLE: begin
				if (seq_enabled) begin
					seq_deadline = '0;
					outcome.restore_valid = 1'b1;
					outcome.restore_speed = seq_saved_speed;
					seq_enabled = 1'b0;
				end
			end
			default: ;
		endcase
		outcome.state_idx = seq_state;
		return outcome;
	endfunction

	task automatic send_item(logic [1:0] cmd, logic [31:0] now, logic [6:0] roll,
		logic [15:0] spread, logic [7:0] cur, logic typed, result_t want);
		int      gap;
		result_t predicted;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {1'b0, cur, spread, roll, now};
		do @(posedge clk); while (!s_axis_tready);
		predicted = step_sequencer(cmd, now, roll, spread, cur);
		pending_outcomes.push_back(typed ? want : predicted);
	endtask

	// hold off until every outstanding transfer has come back
	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (index < REG_TIMING_LOW)
			seq_rows[index] = value[ROW_W-1:0];
		else
			seq_timing[index - REG_TIMING_LOW] = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_phase_config(int phase);
		logic [CFG_DATA_W-1:0] value;
		slot_t                 dwell;
		int                    left;
		int                    weight;
		int                    mode;
		for (int r = 0; r <= REG_TIMING_HIGH; r++) begin
			value = '0;
			if (phase == 0) begin
				value = '1;
			end else if (phase == 1) begin
				value = '0;
			end else if (r < REG_TIMING_LOW) begin
				mode = $urandom_range(0, 9);
				if (mode < 6) begin
					left = 100;
					for (int j = 0; j < ROW_COUNT; j++) begin
						if (j == ROW_COUNT - 1)
							weight = left;
						else
							weight = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, left);
						left -= weight;
						value[WEIGHT_W*j +: WEIGHT_W] = WEIGHT_W'(weight);
					end
				end else if (mode < 9) begin
					value = CFG_DATA_W'({$urandom, $urandom});
				end else begin
					value[WEIGHT_W*$urandom_range(0, ROW_COUNT - 1) +: WEIGHT_W] =
						WEIGHT_W'($urandom_range(1, 127));
				end
			end else begin
				for (int s = 0; s < 3; s++) begin
					dwell = slot_t'(SLOT_W'($urandom));
					if ($urandom_range(0, 3) == 0)
						dwell.variance = '0;
					value[SLOT_W*s +: SLOT_W] = dwell;
				end
			end
			write_reg(CFG_IDX_W'(r), value);
		end
	endtask

	task automatic run_phase(int target);
		int          worked;
		int          pick;
		logic [1:0]  cmd;
		logic [6:0]  roll;
		worked = 0;
		while (worked < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 80)
				cmd = CMD_TICK;
			else if (pick < 88)
				cmd = CMD_ENABLE;
			else if (pick < 96)
				cmd = CMD_DISABLE;
			else
				cmd = CMD_RESERVED;
			pick = $urandom_range(0, 19);
			if (pick < 15)
				wall_ms += $urandom_range(0, 20000);
			else if (pick == 15)
				wall_ms -= $urandom_range(0, 3000);
			else if (pick < 18)
				wall_ms = $urandom;
			else
				wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 70000);
			roll = 7'(($urandom_range(0, 9) == 0) ? $urandom_range(100, 127)
				: $urandom_range(0, 99));
			worked++;
			send_item(cmd, wall_ms, roll, 16'($urandom), 8'($urandom), 1'b0, NOTHING);
		end
	endtask

	task automatic compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(negedge clk) begin
		if (rx_run == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_run = $urandom_range(4, 60);
		end
		rx_run--;
		case (rx_mode)
			RX_OPEN:      m_axis_tready <= 1'b1;
			RX_COIN:      m_axis_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE:    m_axis_tready <= ($urandom_range(0, 7) == 0);
			RX_ALTERNATE: m_axis_tready <= ~m_axis_tready;
			default:      m_axis_tready <= 1'b1;
		endcase
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_outcomes.size() == 0) begin
				$error("result transfer with no expectation pending");
				mismatches++;
			end else begin
				want = pending_outcomes.pop_front();
				compare_field("transitioned", want.transitioned, m_axis_tuser[0]);
				compare_field("restore_valid", want.restore_valid, m_axis_tuser[1]);
				compare_field("state_idx", want.state_idx, m_axis_tdata[2:0]);
				compare_field("animation", want.animation, m_axis_tdata[5:3]);
				compare_field("speed", want.speed, m_axis_tdata[9:6]);
				compare_field("restore_speed", want.restore_speed, m_axis_tdata[17:10]);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
			|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		for (int r = 0; r < ROW_COUNT; r++)
			seq_rows[r] = '0;
		seq_timing[0] = '0;
		seq_timing[1] = '0;
		seq_state = '0;
		seq_deadline = '0;
		seq_enabled = 1'b0;
		seq_saved_speed = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (DIRECTED[i].is_write) begin
				drain_results();
				write_reg(DIRECTED[i].reg_index, DIRECTED[i].reg_value);
			end else begin
				send_item(DIRECTED[i].cmd, DIRECTED[i].now_ms, DIRECTED[i].pick_roll,
					DIRECTED[i].spread_roll, DIRECTED[i].cur_speed, DIRECTED[i].typed,
					DIRECTED[i].want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			load_phase_config(p);
			run_phase(PHASE_ITEMS);
		end

		drain_results();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending_outcomes.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: files.f
src/wrss_pkg.sv
src/wrss_sub.sv
src/wrss_cfg.sv
src/wrss_core.sv
src/weighted_random_state_sequencer_unit.sv
verif/weighted_random_state_sequencer_unit_test.sv
